// ===== hdl/fdss_pkg.sv =====
// ----------------------------------------------------------------------------
// fdss_pkg: shared types and constants for the four-digit display scanner
// Beat formats, command codes, digit-code constants and the glyph lookup.
// ----------------------------------------------------------------------------
package fdss_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned SEG_W    = 8;
  localparam int unsigned DIGITS   = 4;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned CODE_W   = 7;
  localparam int unsigned PERIOD_W = 8;

  // command codes; the fourth code is unused and ignored
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ERROR = 2'd2;

  // digit codes for the error text: blank, E, r, r
  localparam logic [CODE_W-1:0] CODE_ERR_BLANK = 7'd16;
  localparam logic [CODE_W-1:0] CODE_ERR_E     = 7'd17;
  localparam logic [CODE_W-1:0] CODE_ERR_R0    = 7'd18;
  localparam logic [CODE_W-1:0] CODE_ERR_R1    = 7'd19;

  localparam int unsigned GLYPH_COUNT = 20;
  localparam int unsigned GLYPH_IDX_W = 5;
  localparam logic [SEG_W-1:0] BLANK_PATTERN = 8'hFF;

  localparam logic [SEG_W-1:0] GLYPH_TABLE [GLYPH_COUNT] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
    8'h80, 8'h90, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E,
    8'hFF, 8'h86, 8'hAF, 8'hAF
  };

  // reciprocal constants for exact division of a 16-bit value:
  // q = (v * M) >> S
  localparam int unsigned PROD_W = 33;
  localparam logic [PROD_W-1:0] RECIP_1000 = 33'd67109;
  localparam int unsigned       SHIFT_1000 = 26;
  localparam logic [PROD_W-1:0] RECIP_100  = 33'd83887;
  localparam int unsigned       SHIFT_100  = 23;
  localparam logic [PROD_W-1:0] RECIP_10   = 33'd52429;
  localparam int unsigned       SHIFT_10   = 19;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [VALUE_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [SEG_W-1:0]  segment_pattern;
    logic [DIGITS-1:0] digit_select;
  } out_beat_t;

  function automatic logic [SEG_W-1:0] glyph_of(input logic [CODE_W-1:0] code);
    logic [SEG_W-1:0] pat;
    if (code < CODE_W'(GLYPH_COUNT)) begin
      pat = GLYPH_TABLE[code[GLYPH_IDX_W-1:0]];
    end else begin
      pat = BLANK_PATTERN;
    end
    return pat;
  endfunction

endpackage

// ===== hdl/four_digit_seven_segment_scanner.sv =====
// ----------------------------------------------------------------------------
// four_digit_seven_segment_scanner: multiplexed four-digit display driver
// Stores four digit codes from set/error commands and, on countdown expiry,
// emits the segment byte and one-hot select of the next digit in rotation.
// ----------------------------------------------------------------------------
// Takes one command beat per clock while in_stall is low. A beat is registered
// at acceptance and handled from that register once it can proceed: set splits
// the 16-bit value into thousands/hundreds/tens/units with three parallel
// reciprocal multiplies, error loads the "blank E r r" codes, and a tick counts
// down and, on expiry, loads the output register, so a refresh passes through
// the beat register and then the output register before out_valid. in_stall
// rises only when a refresh tick finds the output register full and stalled.
// The user writes scan_period (reset 5, 0 acts as 1) through the cfg port
// only while the block is idle; it is not enforced. cfg_ready is always high.
module four_digit_seven_segment_scanner (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  fdss_pkg::in_beat_t        in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output fdss_pkg::out_beat_t       out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [fdss_pkg::PERIOD_W-1:0] cfg_data
);
  import fdss_pkg::*;

  logic                  s1_valid_r, s1_valid_nxt;
  in_beat_t              s1_data_r;
  logic [PERIOD_W-1:0]   scan_period_r, scan_period_nxt;
  logic [CODE_W-1:0]     digit_codes_r [DIGITS];
  logic [CODE_W-1:0]     digit_codes_nxt [DIGITS];
  logic [IDX_W-1:0]      scan_index_r, scan_index_nxt;
  logic [PERIOD_W-1:0]   countdown_r, countdown_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_beat_t             out_data_r, out_data_nxt;

  logic                  is_tick, emit, go;
  logic [PERIOD_W-1:0]   reload;
  logic [PROD_W-1:0]     prod_1000, prod_100, prod_10;
  logic [6:0]            q1000;
  logic [9:0]            q100;
  logic [12:0]           q10;
  logic [9:0]            hund_w;
  logic [12:0]           tens_w;
  logic [15:0]           unit_w;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign is_tick  = s1_valid_r && (s1_data_r.command == CMD_TICK);
  assign emit     = is_tick && (countdown_r == '0);
  assign go       = s1_valid_r && (!emit || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !go;

  assign reload = (scan_period_r == '0) ? '0 : scan_period_r - PERIOD_W'(1);

  // exact constant division by reciprocal multiply
  assign prod_1000 = PROD_W'(s1_data_r.value) * RECIP_1000;
  assign prod_100  = PROD_W'(s1_data_r.value) * RECIP_100;
  assign prod_10   = PROD_W'(s1_data_r.value) * RECIP_10;
  assign q1000 = prod_1000[SHIFT_1000 +: 7];
  assign q100  = prod_100[SHIFT_100 +: 10];
  assign q10   = prod_10[SHIFT_10 +: 13];

  // each remainder is the quotient minus ten times the next coarser quotient
  assign hund_w = q100 - 10'(q1000) * 10'd10;
  assign tens_w = q10 - 13'(q100) * 13'd10;
  assign unit_w = s1_data_r.value - 16'(q10) * 16'd10;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_comb begin
    scan_period_nxt = scan_period_r;
    if (cfg_valid && cfg_ready) begin
      scan_period_nxt = cfg_data;
    end
  end

  always_comb begin
    digit_codes_nxt = digit_codes_r;
    scan_index_nxt  = scan_index_r;
    countdown_nxt   = countdown_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_data_nxt    = out_data_r;
    if (go) begin
      case (s1_data_r.command)
        CMD_SET: begin
          digit_codes_nxt[0] = q1000;
          digit_codes_nxt[1] = CODE_W'(hund_w[3:0]);
          digit_codes_nxt[2] = CODE_W'(tens_w[3:0]);
          digit_codes_nxt[3] = CODE_W'(unit_w[3:0]);
        end
        CMD_ERROR: begin
          digit_codes_nxt[0] = CODE_ERR_BLANK;
          digit_codes_nxt[1] = CODE_ERR_E;
          digit_codes_nxt[2] = CODE_ERR_R0;
          digit_codes_nxt[3] = CODE_ERR_R1;
        end
        CMD_TICK: begin
          if (emit) begin
            out_valid_nxt                = 1'b1;
            out_data_nxt.segment_pattern = glyph_of(digit_codes_r[scan_index_r]);
            out_data_nxt.digit_select    = DIGITS'(1) << scan_index_r;
            scan_index_nxt               = scan_index_r + IDX_W'(1);
            countdown_nxt                = reload;
          end else begin
            countdown_nxt = countdown_r - PERIOD_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      scan_period_r <= PERIOD_W'(5);
      digit_codes_r <= '{default: '0};
      scan_index_r  <= '0;
      countdown_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      s1_valid_r    <= s1_valid_nxt;
      scan_period_r <= scan_period_nxt;
      digit_codes_r <= digit_codes_nxt;
      scan_index_r  <= scan_index_nxt;
      countdown_r   <= countdown_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && emit && out_valid_r && out_stall))
    else $error("input stalled without a blocked refresh");

  a_select_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot(out_data_r.digit_select))
    else $error("digit select not one-hot");

  a_emit_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (go && emit) |=> (scan_index_r == $past(scan_index_r) + IDX_W'(1)) && out_valid_r)
    else $error("refresh did not advance scan index");

  a_no_emit_holds_index: assert property (@(posedge clk) disable iff (!rst_n)
    !(go && emit) |=> $stable(scan_index_r))
    else $error("scan index moved without a refresh");
`endif

endmodule
